@@ rtl/env_sensor_compensation_assert.svh @@
// Assertion macros shared by the compensation block.
// Each macro takes a label, an antecedent and a consequent, and samples on aclk.
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("compensation check failed");
`define ESC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("compensation check failed");
`else
`define ESC_ASSERT_SAME(lbl, ante, cons)
`define ESC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/esc_pkg.sv @@
`default_nettype none

package esc_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_PRESS = 2'd1;
    localparam logic [1:0] KIND_HUM   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_CAL_MIXED      = 3'd3;
    localparam logic [2:0] REG_CAL_HUM        = 3'd4;

    // Micro-operation codes.
    localparam logic [3:0] OP_LDC = 4'd0;   // load coefficient or input
    localparam logic [3:0] OP_LDK = 4'd1;   // load constant
    localparam logic [3:0] OP_ADD = 4'd2;
    localparam logic [3:0] OP_SUB = 4'd3;
    localparam logic [3:0] OP_MUL = 4'd4;
    localparam logic [3:0] OP_ASR = 4'd5;
    localparam logic [3:0] OP_SHL = 4'd6;
    localparam logic [3:0] OP_W32 = 4'd7;   // wrap to 32-bit two's complement
    localparam logic [3:0] OP_DIV = 4'd8;
    localparam logic [3:0] OP_BZ  = 4'd9;   // zero divisor exit
    localparam logic [3:0] OP_SAT = 4'd10;  // saturate to signed 32 bits
    localparam logic [3:0] OP_CLH = 4'd11;  // clamp humidity
    localparam logic [3:0] OP_STF = 4'd12;  // store fine temperature
    localparam logic [3:0] OP_END = 4'd13;

    // Operand selects for OP_LDC.
    localparam int C_ADC20 = 0;
    localparam int C_ADC16 = 1;
    localparam int C_FINE  = 2;
    localparam int C_T1 = 3;
    localparam int C_T2 = 4;
    localparam int C_T3 = 5;
    localparam int C_P1 = 6;
    localparam int C_P2 = 7;
    localparam int C_P3 = 8;
    localparam int C_P4 = 9;
    localparam int C_P5 = 10;
    localparam int C_P6 = 11;
    localparam int C_P7 = 12;
    localparam int C_P8 = 13;
    localparam int C_P9 = 14;
    localparam int C_H1 = 15;
    localparam int C_H2 = 16;
    localparam int C_H3 = 17;
    localparam int C_H4 = 18;
    localparam int C_H5 = 19;
    localparam int C_H6 = 20;

    // Constant selects for OP_LDK.
    localparam int K_128000   = 0;
    localparam int K_1048576  = 1;
    localparam int K_3125     = 2;
    localparam int K_76800    = 3;
    localparam int K_16384    = 4;
    localparam int K_2097152  = 5;
    localparam int K_8192     = 6;
    localparam int K_32768    = 7;
    localparam int K_ONE      = 8;
    localparam int K_FIVE     = 9;
    localparam int K_128      = 10;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] HUM_MAX = 64'sd419430400;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] dst;
        logic [2:0] srca;
        logic [2:0] srcb;
        logic [5:0] imm;
    } uop_t;

    typedef struct packed {
        logic [39:0] hum;
        logic [47:0] mixed;
        logic [63:0] press_high;
        logic [63:0] press_low;
        logic [47:0] temp;
    } cal_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        zero;
    } res_t;

    function automatic uop_t mk(input logic [3:0] op, input int d, input int a,
                                input int b, input int imm);
        uop_t u;
        u.op   = op;
        u.dst  = 3'(d);
        u.srca = 3'(a);
        u.srcb = 3'(b);
        u.imm  = 6'(imm);
        return u;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] kconst(input logic [5:0] sel);
        logic [63:0] k;
        case (sel)
            6'(K_128000):  k = 64'd128000;
            6'(K_1048576): k = 64'd1048576;
            6'(K_3125):    k = 64'd3125;
            6'(K_76800):   k = 64'd76800;
            6'(K_16384):   k = 64'd16384;
            6'(K_2097152): k = 64'd2097152;
            6'(K_8192):    k = 64'd8192;
            6'(K_32768):   k = 64'd32768;
            6'(K_ONE):     k = 64'd1;
            6'(K_FIVE):    k = 64'd5;
            6'(K_128):     k = 64'd128;
            default:       k = 64'd0;
        endcase
        return k;
    endfunction

    // Temperature: fine temperature and hundredths of a degree.
    function automatic uop_t prog_temp(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_LDC, 0, 0, 0, C_ADC20);
            6'd1:  u = mk(OP_ASR, 1, 0, 0, 3);
            6'd2:  u = mk(OP_LDC, 2, 0, 0, C_T1);
            6'd3:  u = mk(OP_SHL, 3, 2, 0, 1);
            6'd4:  u = mk(OP_SUB, 1, 1, 3, 0);
            6'd5:  u = mk(OP_LDC, 3, 0, 0, C_T2);
            6'd6:  u = mk(OP_MUL, 1, 1, 3, 0);
            6'd7:  u = mk(OP_ASR, 1, 1, 0, 11);
            6'd8:  u = mk(OP_ASR, 4, 0, 0, 4);
            6'd9:  u = mk(OP_SUB, 4, 4, 2, 0);
            6'd10: u = mk(OP_MUL, 4, 4, 4, 0);
            6'd11: u = mk(OP_ASR, 4, 4, 0, 12);
            6'd12: u = mk(OP_LDC, 3, 0, 0, C_T3);
            6'd13: u = mk(OP_MUL, 4, 4, 3, 0);
            6'd14: u = mk(OP_ASR, 4, 4, 0, 14);
            6'd15: u = mk(OP_ADD, 1, 1, 4, 0);
            6'd16: u = mk(OP_W32, 1, 1, 0, 0);
            6'd17: u = mk(OP_STF, 0, 1, 0, 0);
            6'd18: u = mk(OP_LDK, 3, 0, 0, K_FIVE);
            6'd19: u = mk(OP_MUL, 1, 1, 3, 0);
            6'd20: u = mk(OP_LDK, 3, 0, 0, K_128);
            6'd21: u = mk(OP_ADD, 1, 1, 3, 0);
            6'd22: u = mk(OP_ASR, 1, 1, 0, 8);
            default: u = mk(OP_END, 0, 1, 0, 0);
        endcase
        return u;
    endfunction

    // Pressure: 64-bit path with one long division.
    function automatic uop_t prog_press(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_LDC, 0, 0, 0, C_FINE);
            6'd1:  u = mk(OP_LDK, 1, 0, 0, K_128000);
            6'd2:  u = mk(OP_SUB, 0, 0, 1, 0);
            6'd3:  u = mk(OP_MUL, 1, 0, 0, 0);
            6'd4:  u = mk(OP_LDC, 2, 0, 0, C_P6);
            6'd5:  u = mk(OP_MUL, 2, 1, 2, 0);
            6'd6:  u = mk(OP_LDC, 3, 0, 0, C_P5);
            6'd7:  u = mk(OP_MUL, 3, 0, 3, 0);
            6'd8:  u = mk(OP_SHL, 3, 3, 0, 17);
            6'd9:  u = mk(OP_ADD, 2, 2, 3, 0);
            6'd10: u = mk(OP_LDC, 3, 0, 0, C_P4);
            6'd11: u = mk(OP_SHL, 3, 3, 0, 35);
            6'd12: u = mk(OP_ADD, 2, 2, 3, 0);
            6'd13: u = mk(OP_LDC, 3, 0, 0, C_P3);
            6'd14: u = mk(OP_MUL, 3, 1, 3, 0);
            6'd15: u = mk(OP_ASR, 3, 3, 0, 8);
            6'd16: u = mk(OP_LDC, 4, 0, 0, C_P2);
            6'd17: u = mk(OP_MUL, 4, 0, 4, 0);
            6'd18: u = mk(OP_SHL, 4, 4, 0, 12);
            6'd19: u = mk(OP_ADD, 3, 3, 4, 0);
            6'd20: u = mk(OP_LDK, 4, 0, 0, K_ONE);
            6'd21: u = mk(OP_SHL, 4, 4, 0, 47);
            6'd22: u = mk(OP_ADD, 3, 4, 3, 0);
            6'd23: u = mk(OP_LDC, 4, 0, 0, C_P1);
            6'd24: u = mk(OP_MUL, 3, 3, 4, 0);
            6'd25: u = mk(OP_ASR, 3, 3, 0, 33);
            6'd26: u = mk(OP_BZ,  0, 3, 0, 0);
            6'd27: u = mk(OP_LDC, 0, 0, 0, C_ADC20);
            6'd28: u = mk(OP_LDK, 1, 0, 0, K_1048576);
            6'd29: u = mk(OP_SUB, 1, 1, 0, 0);
            6'd30: u = mk(OP_SHL, 1, 1, 0, 31);
            6'd31: u = mk(OP_SUB, 1, 1, 2, 0);
            6'd32: u = mk(OP_LDK, 4, 0, 0, K_3125);
            6'd33: u = mk(OP_MUL, 1, 1, 4, 0);
            6'd34: u = mk(OP_DIV, 1, 1, 3, 0);
            6'd35: u = mk(OP_ASR, 4, 1, 0, 13);
            6'd36: u = mk(OP_LDC, 5, 0, 0, C_P9);
            6'd37: u = mk(OP_MUL, 5, 5, 4, 0);
            6'd38: u = mk(OP_MUL, 5, 5, 4, 0);
            6'd39: u = mk(OP_ASR, 5, 5, 0, 25);
            6'd40: u = mk(OP_LDC, 6, 0, 0, C_P8);
            6'd41: u = mk(OP_MUL, 6, 6, 1, 0);
            6'd42: u = mk(OP_ASR, 6, 6, 0, 19);
            6'd43: u = mk(OP_ADD, 1, 1, 5, 0);
            6'd44: u = mk(OP_ADD, 1, 1, 6, 0);
            6'd45: u = mk(OP_ASR, 1, 1, 0, 8);
            6'd46: u = mk(OP_LDC, 6, 0, 0, C_P7);
            6'd47: u = mk(OP_SHL, 6, 6, 0, 4);
            6'd48: u = mk(OP_ADD, 1, 1, 6, 0);
            6'd49: u = mk(OP_SAT, 1, 1, 0, 0);
            default: u = mk(OP_END, 0, 1, 0, 0);
        endcase
        return u;
    endfunction

    // Humidity: every step wraps to 32 bits.
    function automatic uop_t prog_hum(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_LDC, 0, 0, 0, C_FINE);
            6'd1:  u = mk(OP_LDK, 1, 0, 0, K_76800);
            6'd2:  u = mk(OP_SUB, 0, 0, 1, 0);
            6'd3:  u = mk(OP_W32, 0, 0, 0, 0);
            6'd4:  u = mk(OP_LDC, 1, 0, 0, C_ADC16);
            6'd5:  u = mk(OP_SHL, 1, 1, 0, 14);
            6'd6:  u = mk(OP_W32, 1, 1, 0, 0);
            6'd7:  u = mk(OP_LDC, 2, 0, 0, C_H4);
            6'd8:  u = mk(OP_SHL, 2, 2, 0, 20);
            6'd9:  u = mk(OP_W32, 2, 2, 0, 0);
            6'd10: u = mk(OP_SUB, 1, 1, 2, 0);
            6'd11: u = mk(OP_W32, 1, 1, 0, 0);
            6'd12: u = mk(OP_LDC, 2, 0, 0, C_H5);
            6'd13: u = mk(OP_MUL, 2, 2, 0, 0);
            6'd14: u = mk(OP_W32, 2, 2, 0, 0);
            6'd15: u = mk(OP_SUB, 1, 1, 2, 0);
            6'd16: u = mk(OP_W32, 1, 1, 0, 0);
            6'd17: u = mk(OP_LDK, 2, 0, 0, K_16384);
            6'd18: u = mk(OP_ADD, 1, 1, 2, 0);
            6'd19: u = mk(OP_W32, 1, 1, 0, 0);
            6'd20: u = mk(OP_ASR, 1, 1, 0, 15);
            6'd21: u = mk(OP_LDC, 2, 0, 0, C_H6);
            6'd22: u = mk(OP_MUL, 2, 0, 2, 0);
            6'd23: u = mk(OP_W32, 2, 2, 0, 0);
            6'd24: u = mk(OP_ASR, 2, 2, 0, 10);
            6'd25: u = mk(OP_LDC, 3, 0, 0, C_H3);
            6'd26: u = mk(OP_MUL, 3, 0, 3, 0);
            6'd27: u = mk(OP_W32, 3, 3, 0, 0);
            6'd28: u = mk(OP_ASR, 3, 3, 0, 11);
            6'd29: u = mk(OP_LDK, 4, 0, 0, K_32768);
            6'd30: u = mk(OP_ADD, 3, 3, 4, 0);
            6'd31: u = mk(OP_W32, 3, 3, 0, 0);
            6'd32: u = mk(OP_MUL, 2, 2, 3, 0);
            6'd33: u = mk(OP_W32, 2, 2, 0, 0);
            6'd34: u = mk(OP_ASR, 2, 2, 0, 10);
            6'd35: u = mk(OP_LDK, 4, 0, 0, K_2097152);
            6'd36: u = mk(OP_ADD, 2, 2, 4, 0);
            6'd37: u = mk(OP_W32, 2, 2, 0, 0);
            6'd38: u = mk(OP_LDC, 4, 0, 0, C_H2);
            6'd39: u = mk(OP_MUL, 2, 2, 4, 0);
            6'd40: u = mk(OP_W32, 2, 2, 0, 0);
            6'd41: u = mk(OP_LDK, 4, 0, 0, K_8192);
            6'd42: u = mk(OP_ADD, 2, 2, 4, 0);
            6'd43: u = mk(OP_W32, 2, 2, 0, 0);
            6'd44: u = mk(OP_ASR, 2, 2, 0, 14);
            6'd45: u = mk(OP_MUL, 1, 1, 2, 0);
            6'd46: u = mk(OP_W32, 1, 1, 0, 0);
            6'd47: u = mk(OP_ASR, 3, 1, 0, 15);
            6'd48: u = mk(OP_MUL, 3, 3, 3, 0);
            6'd49: u = mk(OP_W32, 3, 3, 0, 0);
            6'd50: u = mk(OP_ASR, 3, 3, 0, 7);
            6'd51: u = mk(OP_LDC, 4, 0, 0, C_H1);
            6'd52: u = mk(OP_MUL, 3, 3, 4, 0);
            6'd53: u = mk(OP_W32, 3, 3, 0, 0);
            6'd54: u = mk(OP_ASR, 3, 3, 0, 4);
            6'd55: u = mk(OP_SUB, 1, 1, 3, 0);
            6'd56: u = mk(OP_W32, 1, 1, 0, 0);
            6'd57: u = mk(OP_CLH, 1, 1, 0, 0);
            6'd58: u = mk(OP_ASR, 1, 1, 0, 12);
            default: u = mk(OP_END, 0, 1, 0, 0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ rtl/esc_mul.sv @@
`default_nettype none

// Wrapping 64 x 64 multiply built from one 32 x 32 multiplier over four steps.
module esc_mul import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg, b_reg, prod_reg, acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] mx, my;

    // Pick the partial product for this step; the high by high term wraps away.
    always_comb begin
        case (step_reg)
            2'd0: begin
                mx = a_reg[31:0];
                my = b_reg[31:0];
            end
            2'd1: begin
                mx = a_reg[63:32];
                my = b_reg[31:0];
            end
            default: begin
                mx = a_reg[31:0];
                my = b_reg[63:32];
            end
        endcase
    end

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Product register, then accumulation of the shifted cross terms.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end else if (busy_reg) begin
            prod_reg <= {32'd0, mx} * {32'd0, my};
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            endcase
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

@@ rtl/esc_div.sv @@
`default_nettype none

// Signed 64-bit division truncating toward zero, one quotient bit per cycle.
module esc_div import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] q
);

    logic [63:0] quo_reg, rem_reg, ub_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg, neg_reg;
    logic [63:0] rem_sh, rem_sub;
    logic        fits;

    assign rem_sh  = {rem_reg[62:0], quo_reg[63]};
    assign fits    = rem_sh >= ub_reg;
    assign rem_sub = rem_sh - ub_reg;

    // Control sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 6'd0;
                // A divisor of minus one is a plain negation.
                if (&b) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division on magnitudes.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= 64'd0;
            if (&b) begin
                quo_reg <= a;
                neg_reg <= 1'b1;
            end else begin
                quo_reg <= a[63] ? (~a + 64'd1) : a;
                ub_reg  <= b[63] ? (~b + 64'd1) : b;
                neg_reg <= a[63] ^ b[63];
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? (~quo_reg + 64'd1) : quo_reg;

endmodule

`default_nettype wire

@@ rtl/esc_core.sv @@
`default_nettype none

// Micro-coded sequencer: a small register file, a simple ALU, and the shared
// multiplier and divider, stepping through one formula per request kind.
module esc_core import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [19:0] raw,
    input  cal_t        cal,
    input  logic        out_free,
    output logic        idle,
    output logic        res_valid,
    output res_t        res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         state_reg;
    logic [5:0]         pc_reg;
    logic signed [31:0] fine_reg;
    logic [1:0]         kind_reg;
    logic [19:0]        raw_reg;
    logic [31:0]        val_reg;
    logic               zero_reg;

    logic [63:0] rf [8];
    logic [63:0] opa_reg, opb_reg;

    uop_t        uop;
    logic [63:0] coef, alu_out, wr_data, mul_p, div_q;
    logic        alu_wr, wr_en, mul_start, mul_done, div_start, div_done;

    // Program ROM of the active request kind.
    always_comb begin
        unique case (kind_reg)
            KIND_TEMP:  uop = prog_temp(pc_reg);
            KIND_PRESS: uop = prog_press(pc_reg);
            default:    uop = prog_hum(pc_reg);
        endcase
    end

    // Coefficient and input fields, extended to 64 bits.
    always_comb begin
        case (uop.imm)
            6'(C_ADC20): coef = {44'd0, raw_reg};
            6'(C_ADC16): coef = {48'd0, raw_reg[15:0]};
            6'(C_FINE):  coef = {{32{fine_reg[31]}}, fine_reg};
            6'(C_T1):    coef = {48'd0, cal.temp[15:0]};
            6'(C_T2):    coef = sx16(cal.temp[31:16]);
            6'(C_T3):    coef = sx16(cal.temp[47:32]);
            6'(C_P1):    coef = {48'd0, cal.press_low[15:0]};
            6'(C_P2):    coef = sx16(cal.press_low[31:16]);
            6'(C_P3):    coef = sx16(cal.press_low[47:32]);
            6'(C_P4):    coef = sx16(cal.press_low[63:48]);
            6'(C_P5):    coef = sx16(cal.press_high[15:0]);
            6'(C_P6):    coef = sx16(cal.press_high[31:16]);
            6'(C_P7):    coef = sx16(cal.press_high[47:32]);
            6'(C_P8):    coef = sx16(cal.press_high[63:48]);
            6'(C_P9):    coef = sx16(cal.mixed[15:0]);
            6'(C_H1):    coef = {56'd0, cal.mixed[23:16]};
            6'(C_H2):    coef = sx16(cal.mixed[39:24]);
            6'(C_H3):    coef = {56'd0, cal.mixed[47:40]};
            6'(C_H4):    coef = sx16(cal.hum[15:0]);
            6'(C_H5):    coef = sx16(cal.hum[31:16]);
            6'(C_H6):    coef = {{56{cal.hum[39]}}, cal.hum[39:32]};
            default:     coef = 64'd0;
        endcase
    end

    // Combinational ALU operations.
    always_comb begin
        alu_wr  = 1'b1;
        alu_out = 64'd0;
        unique case (uop.op)
            OP_LDC: alu_out = coef;
            OP_LDK: alu_out = kconst(uop.imm);
            OP_ADD: alu_out = opa_reg + opb_reg;
            OP_SUB: alu_out = opa_reg - opb_reg;
            OP_ASR: alu_out = 64'($signed(opa_reg) >>> uop.imm);
            OP_SHL: alu_out = opa_reg << uop.imm;
            OP_W32: alu_out = {{32{opa_reg[31]}}, opa_reg[31:0]};
            OP_SAT: begin
                if ($signed(opa_reg) > SAT_MAX) begin
                    alu_out = SAT_MAX;
                end else if ($signed(opa_reg) < SAT_MIN) begin
                    alu_out = SAT_MIN;
                end else begin
                    alu_out = opa_reg;
                end
            end
            OP_CLH: begin
                if ($signed(opa_reg) < 64'sd0) begin
                    alu_out = 64'd0;
                end else if ($signed(opa_reg) > HUM_MAX) begin
                    alu_out = HUM_MAX;
                end else begin
                    alu_out = opa_reg;
                end
            end
            default: alu_wr = 1'b0;
        endcase
    end

    assign mul_start = (state_reg == S_EXEC) && (uop.op == OP_MUL);
    assign div_start = (state_reg == S_EXEC) && (uop.op == OP_DIV);

    esc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (opa_reg),
        .b       (opb_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    esc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (opa_reg),
        .b       (opb_reg),
        .done    (div_done),
        .q       (div_q)
    );

    // Register file write port.
    assign wr_en = ((state_reg == S_EXEC) && alu_wr) ||
                   ((state_reg == S_MUL) && mul_done) ||
                   ((state_reg == S_DIV) && div_done);
    assign wr_data = (state_reg == S_MUL) ? mul_p :
                     (state_reg == S_DIV) ? div_q : alu_out;

    // Register file with registered operand reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf[uop.dst] <= wr_data;
        end
        opa_reg <= rf[uop.srca];
        opb_reg <= rf[uop.srcb];
    end

    // Sequencer and stored fine temperature.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg    <= 6'd0;
            fine_reg  <= 32'sd0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        pc_reg    <= 6'd0;
                        state_reg <= (kind == KIND_TEMP || kind == KIND_PRESS ||
                                      kind == KIND_HUM) ? S_READ : S_OUT;
                    end
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC: begin
                    case (uop.op)
                        OP_MUL: state_reg <= S_MUL;
                        OP_DIV: state_reg <= S_DIV;
                        OP_END: state_reg <= S_OUT;
                        OP_BZ: begin
                            if (opa_reg == 64'd0) begin
                                state_reg <= S_OUT;
                            end else begin
                                pc_reg    <= pc_reg + 6'd1;
                                state_reg <= S_READ;
                            end
                        end
                        default: begin
                            if (uop.op == OP_STF) begin
                                fine_reg <= opa_reg[31:0];
                            end
                            pc_reg    <= pc_reg + 6'd1;
                            state_reg <= S_READ;
                        end
                    endcase
                end
                S_MUL: begin
                    if (mul_done) begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= S_READ;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        pc_reg    <= pc_reg + 6'd1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            kind_reg <= kind;
            raw_reg  <= raw;
            val_reg  <= 32'd0;
            zero_reg <= 1'b0;
        end else if (state_reg == S_EXEC && uop.op == OP_END) begin
            val_reg <= opa_reg[31:0];
        end else if (state_reg == S_EXEC && uop.op == OP_BZ && opa_reg == 64'd0) begin
            zero_reg <= 1'b1;
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT) && out_free;
    assign res.kind   = kind_reg;
    assign res.value  = val_reg;
    assign res.zero   = zero_reg;

endmodule

`default_nettype wire

@@ rtl/env_sensor_compensation.sv @@
// Channel   Direction  Payload
// s_        in         tuser[1:0] req_type, tdata[19:0] raw_reading
// m_        out        tuser[1:0] reading_kind, tuser[2] zero_divisor,
//                      tdata[31:0] compensated_value
// APB       in         five calibration registers at byte address 8*i
//
// One request at a time; each micro-op passes through a read state and an
// execute state, and a multiply or divide waits for the shared multiplier or
// divider. An unknown kind goes straight to the output state. s_tready is low
// while a request runs; a result waits in the output register while m_tready
// is low, and the next request is accepted meanwhile. Reset is synchronous and
// clears the control and calibration state, but not the datapath registers.
`default_nettype none

module env_sensor_compensation import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] raw_reading, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] compensated_value
    output logic [2:0]  m_tuser,   // [1:0] reading_kind, [2] zero_divisor
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "env_sensor_compensation_assert.svh"

    cal_t        cal_reg;
    logic        core_idle, res_valid, out_free, cfg_wr;
    res_t        res;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    // Calibration register writes.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_CAL_TEMP:       cal_reg.temp       <= pwdata[47:0];
                REG_CAL_PRESS_LOW:  cal_reg.press_low  <= pwdata;
                REG_CAL_PRESS_HIGH: cal_reg.press_high <= pwdata;
                REG_CAL_MIXED:      cal_reg.mixed      <= pwdata[47:0];
                REG_CAL_HUM:        cal_reg.hum        <= pwdata[39:0];
                default:            cal_reg            <= cal_reg;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[5:3])
            REG_CAL_TEMP:       prdata = {16'd0, cal_reg.temp};
            REG_CAL_PRESS_LOW:  prdata = cal_reg.press_low;
            REG_CAL_PRESS_HIGH: prdata = cal_reg.press_high;
            REG_CAL_MIXED:      prdata = {16'd0, cal_reg.mixed};
            REG_CAL_HUM:        prdata = {24'd0, cal_reg.hum};
            default:            prdata = 64'd0;
        endcase
    end

    assign s_tready = core_idle;
    assign out_free = !m_tvalid_reg || m_tready;

    esc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && s_tready),
        .kind      (s_tuser),
        .raw       (s_tdata[19:0]),
        .cal       (cal_reg),
        .out_free  (out_free),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= res.value;
            m_tuser_reg <= {res.zero, res.kind};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An accepted request keeps the input closed while it runs.
    `ESC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // The zero divisor flag only marks pressure results forced to zero.
    `ESC_ASSERT_SAME(a_zero_flag_press, m_tvalid && m_tuser[2], m_tuser[1:0] == KIND_PRESS && m_tdata == 32'd0)
    // A new result never overwrites one that is still waiting.
    `ESC_ASSERT_SAME(a_no_overwrite, res_valid, !m_tvalid_reg || m_tready)

endmodule

`default_nettype wire
